// ----- rtl/core/perc_pkg.sv -----
// shared types and constants for the polygon edge rectangle clipper
package perc_pkg;

   localparam int CoordBits = 16;
   localparam int WideBits  = CoordBits + 3;
   localparam int QuoBits   = CoordBits + 2;
   localparam int CsrIdxBits = 2;
   localparam int DivCntBits = $clog2(2 * WideBits + 2);

   localparam logic [CsrIdxBits-1:0] CsrLeft   = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrTop    = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrRight  = 2'd2;
   localparam logic [CsrIdxBits-1:0] CsrBottom = 2'd3;

   typedef struct packed {
      logic signed [CoordBits-1:0] vertex_x;
      logic signed [CoordBits-1:0] vertex_y;
      logic                        vertex_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [CoordBits-1:0] seg_start_x;
      logic signed [CoordBits-1:0] seg_start_y;
      logic signed [CoordBits-1:0] seg_end_x;
      logic signed [CoordBits-1:0] seg_end_y;
      logic                        seg_valid;
      logic                        polygon_end;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETUP,
      ST_DIV,
      ST_APPLY,
      ST_NEXT,
      ST_EMIT,
      ST_WAIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;     // latch input vertex
      logic       first_vtx;  // latched vertex opens a polygon
      logic       load_close; // load closing edge into the work segment
      logic       load_open;  // load ordinary edge
      logic [1:0] plane;
      logic       setup;      // evaluate plane, start divider if needed
      logic       div_step;
      logic       apply;
      logic       emit;       // place result into output register
      logic       emit_end;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic have_start;
      logic last;
      logic need_div;
      logic seg_ok;
      logic div_done;
   } sts_type;

endpackage

// ----- rtl/core/perc_ctrl.sv -----
// sequencer for edge forming, four clip planes and result hand-off
module perc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              out_busy,
   input  perc_pkg::sts_type sts,
   output perc_pkg::cmd_type cmd
);
   import perc_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] plane_ff, plane_in;
   logic       closing_ff, closing_in;   // working on closing edge
   logic       pend_close_ff, pend_close_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         plane_ff      <= 2'd0;
         closing_ff    <= 1'b0;
         pend_close_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         plane_ff      <= plane_in;
         closing_ff    <= closing_in;
         pend_close_ff <= pend_close_in;
      end
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      plane_in      = plane_ff;
      closing_in    = closing_ff;
      pend_close_in = pend_close_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // sts reflects the latched vertex and the old have_start
            plane_in = 2'd0;
            if (sts.have_start) begin
               closing_in    = 1'b0;
               pend_close_in = sts.last;
               state_in      = ST_SETUP;
            end else if (sts.last) begin
               closing_in    = 1'b1;
               pend_close_in = 1'b0;
               state_in      = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            state_in = sts.need_div ? ST_DIV : ST_NEXT;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_NEXT;
         ST_NEXT: begin
            if (plane_ff == 2'd3 || !sts.seg_ok) begin
               state_in = ST_EMIT;
            end else begin
               plane_in = plane_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end
         ST_EMIT: begin
            if (!out_busy) begin
               if (pend_close_ff) begin
                  pend_close_in = 1'b0;
                  closing_in    = 1'b1;
                  plane_in      = 2'd0;
                  state_in      = ST_WAIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WAIT: state_in = ST_SETUP;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      cmd.plane  = plane_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_LOAD: begin
            cmd.first_vtx  = !sts.have_start;
            cmd.load_open  = sts.have_start;
            cmd.load_close = !sts.have_start && sts.last;
         end
         ST_SETUP: cmd.setup    = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_APPLY: cmd.apply    = 1'b1;
         ST_EMIT: begin
            // ordinary edges that clip away are dropped
            cmd.emit     = !out_busy && (closing_ff || sts.seg_ok);
            cmd.emit_end = closing_ff;
         end
         ST_WAIT: cmd.load_close = 1'b1;
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/perc_dpath.sv -----
// vertex store, clip arithmetic with serial divider, and output register
module perc_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  perc_pkg::req_payload_type req_data,
   input  logic                      csr_write,
   input  logic [perc_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [perc_pkg::CoordBits-1:0]  csr_data,
   input  perc_pkg::cmd_type         cmd,
   output perc_pkg::sts_type         sts,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output perc_pkg::rsp_payload_type rsp_data,
   output logic                      out_busy
);
   import perc_pkg::*;

   logic signed [CoordBits-1:0] left_ff, top_ff, right_ff, bottom_ff;
   logic signed [CoordBits-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CoordBits-1:0] cur_x_ff, cur_y_ff;
   logic                        have_start_ff, last_ff;

   // work segment
   logic signed [CoordBits-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic                        ok_ff;

   // per-plane setup results
   logic                        hi_sel_ff;   // 1: point 1 is the outer one
   logic                        neg_ff;
   logic signed [CoordBits-1:0] lim_ff, wl_ff;
   logic [WideBits-1:0]         den_ff;      // 2*(uh-ul)
   logic [2*WideBits+1:0]       num_ff;      // dividend shifted through
   logic [WideBits:0]           rem_ff;
   logic [QuoBits-1:0]          quo_ff;
   logic [DivCntBits-1:0]       cnt_ff;

   logic                        rsp_valid_ff;
   rsp_payload_type             rsp_data_ff;

   // plane selection: planes 0,1 keep u<=lim, 2,3 keep u>=lim
   logic                        on_y, flip;
   logic signed [CoordBits-1:0] lim;
   logic signed [CoordBits:0]   u0, u1, w0, w1, v;
   logic                        sel1;
   logic signed [CoordBits:0]   ul, uh, wl, wh;
   logic signed [CoordBits+1:0] dw, t, d;
   logic [CoordBits+1:0]        adw;
   logic [2*CoordBits+3:0]      prod;
   logic [2*WideBits+1:0]       dividend;
   logic [WideBits:0]           rem_sh, rem_sub;
   logic signed [CoordBits+1:0] wnew;
   logic signed [CoordBits-1:0] wres;

   always_comb begin
      on_y = cmd.plane[0];
      flip = cmd.plane[1];
      case (cmd.plane)
         2'd0:    lim = right_ff;
         2'd1:    lim = bottom_ff;
         2'd2:    lim = left_ff;
         default: lim = top_ff;
      endcase
      u0 = on_y ? {y0_ff[CoordBits-1], y0_ff} : {x0_ff[CoordBits-1], x0_ff};
      u1 = on_y ? {y1_ff[CoordBits-1], y1_ff} : {x1_ff[CoordBits-1], x1_ff};
      w0 = on_y ? {x0_ff[CoordBits-1], x0_ff} : {y0_ff[CoordBits-1], y0_ff};
      w1 = on_y ? {x1_ff[CoordBits-1], x1_ff} : {y1_ff[CoordBits-1], y1_ff};
      v  = {lim[CoordBits-1], lim};
      if (flip) begin
         u0 = -u0;
         u1 = -u1;
         v  = -v;
      end
      sel1 = !(u1 < u0);  // high point: end wins ties
      uh = sel1 ? u1 : u0;
      ul = sel1 ? u0 : u1;
      wh = sel1 ? w1 : w0;
      wl = sel1 ? w0 : w1;
      dw = {wh[CoordBits], wh} - {wl[CoordBits], wl};
      t  = {v[CoordBits], v} - {ul[CoordBits], ul};
      d  = {uh[CoordBits], uh} - {ul[CoordBits], ul};
      adw = dw[CoordBits+1] ? -dw : dw;
      // floor((2*|dw|*t + d - neg) / (2d))
      prod = adw * t[CoordBits+1:0];
      dividend = {3'b000, prod, 1'b0}
               + (2*WideBits+2)'({d[CoordBits+1:0]})
               - (2*WideBits+2)'(dw[CoordBits+1]);
      rem_sh  = {rem_ff[WideBits-1:0], num_ff[2*WideBits+1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      wnew = neg_ff ? {wl_ff[CoordBits-1], wl_ff[CoordBits-1], wl_ff} - (CoordBits+2)'(quo_ff)
                    : {wl_ff[CoordBits-1], wl_ff[CoordBits-1], wl_ff} + (CoordBits+2)'(quo_ff);
      wres = wnew[CoordBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         top_ff        <= '0;
         right_ff      <= '0;
         bottom_ff     <= '0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_start_ff <= 1'b0;
         ok_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrLeft:   left_ff   <= csr_data;
               CsrTop:    top_ff    <= csr_data;
               CsrRight:  right_ff  <= csr_data;
               CsrBottom: bottom_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            cur_x_ff <= req_data.vertex_x;
            cur_y_ff <= req_data.vertex_y;
            last_ff  <= req_data.vertex_last;
         end
         if (cmd.load_open) begin
            x0_ff <= prev_x_ff;
            y0_ff <= prev_y_ff;
            x1_ff <= cur_x_ff;
            y1_ff <= cur_y_ff;
            ok_ff <= 1'b1;
         end
         if (cmd.load_close) begin
            // first vertex may be the current one on a new polygon
            x0_ff <= cur_x_ff;
            y0_ff <= cur_y_ff;
            x1_ff <= have_start_ff ? first_x_ff : cur_x_ff;
            y1_ff <= have_start_ff ? first_y_ff : cur_y_ff;
            ok_ff <= 1'b1;
         end
         if (cmd.load_open || cmd.load_close || cmd.first_vtx) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
         if (cmd.setup) begin
            hi_sel_ff <= sel1;
            neg_ff    <= dw[CoordBits+1];
            lim_ff    <= lim;
            wl_ff     <= wl[CoordBits-1:0];
            den_ff    <= {d[WideBits-2:0], 1'b0};
            num_ff    <= dividend;
            rem_ff    <= '0;
            quo_ff    <= '0;
            cnt_ff    <= '0;
            if (ok_ff) begin
               if (x0_ff == x1_ff && y0_ff == y1_ff) begin
                  ok_ff <= 1'b0;
               end else if (uh <= v) begin
                  ok_ff <= 1'b1;
               end else if (!(ul < v)) begin
                  ok_ff <= 1'b0;
               end
            end
         end
         if (cmd.div_step) begin
            num_ff <= {num_ff[2*WideBits:0], 1'b0};
            cnt_ff <= cnt_ff + DivCntBits'(1);
            if (!rem_sub[WideBits]) begin
               rem_ff <= rem_sub;
               quo_ff <= {quo_ff[QuoBits-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[QuoBits-2:0], 1'b0};
            end
         end
         if (cmd.apply) begin
            if (hi_sel_ff) begin
               if (cmd.plane[0]) begin
                  y1_ff <= lim_ff; x1_ff <= wres;
               end else begin
                  x1_ff <= lim_ff; y1_ff <= wres;
               end
            end else begin
               if (cmd.plane[0]) begin
                  y0_ff <= lim_ff; x0_ff <= wres;
               end else begin
                  x0_ff <= lim_ff; y0_ff <= wres;
               end
            end
         end
         if (cmd.emit && cmd.emit_end) begin
            have_start_ff <= 1'b0;
         end else if (cmd.first_vtx) begin
            have_start_ff <= 1'b1;
         end
         if (cmd.first_vtx) begin
            first_x_ff <= cur_x_ff;
            first_y_ff <= cur_y_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff.seg_start_x <= ok_ff ? x0_ff : '0;
            rsp_data_ff.seg_start_y <= ok_ff ? y0_ff : '0;
            rsp_data_ff.seg_end_x   <= ok_ff ? x1_ff : '0;
            rsp_data_ff.seg_end_y   <= ok_ff ? y1_ff : '0;
            rsp_data_ff.seg_valid   <= ok_ff;
            rsp_data_ff.polygon_end <= cmd.emit_end;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.have_start = have_start_ff;
      sts.last       = last_ff;
      sts.need_div   = ok_ff && !(x0_ff == x1_ff && y0_ff == y1_ff) && !(uh <= v) && (ul < v);
      sts.seg_ok     = ok_ff;
      sts.div_done   = (cnt_ff == DivCntBits'(2*WideBits+1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_busy  = rsp_valid_ff && rsp_stall;

endmodule

// ----- rtl/core/polygon_edge_rect_clipper.sv -----
// polygon edge clipper against a configured rectangle: top level
// a vertex is taken only while idle; LOAD forms its edge, then each clip plane runs SETUP
// and NEXT, with DIV (40-step restoring divider) and APPLY between when the plane cuts the
// edge; EMIT registers the result. An opening vertex only stores its point; a last vertex
// also clips the closing edge. A null or clipped-away edge stops early, a held result waits
// reset clears the rectangle to zero, the vertex history and the result valid flag
module polygon_edge_rect_clipper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  perc_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output perc_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_write,
   input  logic [perc_pkg::CsrIdxBits-1:0]   csr_index,
   input  logic [perc_pkg::CoordBits-1:0]    csr_data
);
   import perc_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    out_busy;

   perc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (out_busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   perc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .out_busy  (out_busy)
   );

endmodule
